>>> rtl/epcs_pkg.sv
// ----------------------------------------------------------------------------
// Edge pair compatibility scores: shared constants
// Default widths, length guard bits and the register reset value.
// ----------------------------------------------------------------------------
package epcs_pkg;

	localparam int COORD_BITS      = 16;
	localparam int SCORE_FRAC_BITS = 16;
	// extra fraction bits kept on edge lengths and midpoint distance
	localparam int LEN_GUARD_BITS  = 8;
	localparam int MML_BITS        = 16;
	localparam logic [MML_BITS-1:0] MML_RESET = 16'd1;

endpackage

>>> rtl/epcs_div.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage, QUO_W stages. The quotient must fit in QUO_W
// bits; the caller forces den to one and num to zero when it has no answer.
// ----------------------------------------------------------------------------
module epcs_div #(
	parameter int NUM_W = 33,
	parameter int DEN_W = 16,
	parameter int QUO_W = 17
) (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [QUO_W-1:0] quo
);

	logic [DEN_W-1:0] rem_q [1:QUO_W];
	logic [DEN_W-1:0] den_q [1:QUO_W];
	logic [QUO_W-1:0] low_q [1:QUO_W];
	logic [QUO_W-1:0] quo_q [1:QUO_W];

	for (genvar k = 0; k < QUO_W; k++) begin : g_step
		logic [DEN_W-1:0] rem_in;
		logic [DEN_W-1:0] den_in;
		logic [QUO_W-1:0] low_in;
		logic [QUO_W-1:0] quo_in;
		logic [DEN_W:0]   trial;
		logic             ge;

		if (k == 0) begin : g_first
			// upper numerator bits start as the partial remainder
			assign rem_in = DEN_W'(num >> QUO_W);
			assign den_in = den;
			assign low_in = num[QUO_W-1:0];
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_q[k];
			assign den_in = den_q[k];
			assign low_in = low_q[k];
			assign quo_in = quo_q[k];
		end

		assign trial = {rem_in, low_in[QUO_W-1]};
		assign ge    = trial >= {1'b0, den_in};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k+1] <= ge ? DEN_W'(trial - {1'b0, den_in}) : DEN_W'(trial);
				den_q[k+1] <= den_in;
				low_q[k+1] <= low_in << 1;
				quo_q[k+1] <= {quo_in[QUO_W-2:0], ge};
			end
		end
	end

	assign quo = quo_q[QUO_W];

endmodule

>>> rtl/epcs_isqrt.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Digit by digit, one root bit per stage, IN_W/2 stages, floor result.
// ----------------------------------------------------------------------------
module epcs_isqrt #(
	parameter int IN_W = 34
) (
	input  logic                clk,
	input  logic                en,
	input  logic [IN_W-1:0]     val,
	output logic [IN_W/2-1:0]   root
);

	localparam int RW = IN_W / 2;

	logic [RW+1:0]   rem_q  [1:RW];
	logic [RW-1:0]   root_q [1:RW];
	logic [IN_W-1:0] bits_q [1:RW];

	for (genvar k = 0; k < RW; k++) begin : g_step
		logic [RW+1:0]   rem_in;
		logic [RW-1:0]   root_in;
		logic [IN_W-1:0] bits_in;
		logic [RW+3:0]   cur;
		logic [RW+3:0]   trial;
		logic            ge;

		if (k == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign bits_in = val;
		end else begin : g_next
			assign rem_in  = rem_q[k];
			assign root_in = root_q[k];
			assign bits_in = bits_q[k];
		end

		assign cur   = {rem_in, bits_in[IN_W-1:IN_W-2]};
		assign trial = {2'b00, root_in, 2'b01};
		assign ge    = cur >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k+1]  <= ge ? (RW+2)'(cur - trial) : (RW+2)'(cur);
				root_q[k+1] <= {root_in[RW-2:0], ge};
				bits_q[k+1] <= bits_in << 2;
			end
		end
	end

	assign root = root_q[RW];

endmodule

>>> rtl/edge_pair_compatibility_scores.sv
// ----------------------------------------------------------------------------
// Edge pair compatibility scores
// Angle, scale, position and visibility scores for force directed bundling.
// ----------------------------------------------------------------------------
// Depth: the angle path sets it when the coordinate path is shorter, as at
//   defaults (F = 16, C = 16): 2F+1 divider stages followed by F+1 root stages.
//   Otherwise the length path sets it.
// Throughput: one request per cycle; the whole pipe stalls only while the
//   output register holds a result that is not taken.
// Reset clears all valid bits and loads min_mean_length with one.
// ----------------------------------------------------------------------------
module edge_pair_compatibility_scores #(
	parameter int COORD_BITS      = epcs_pkg::COORD_BITS,
	parameter int SCORE_FRAC_BITS = epcs_pkg::SCORE_FRAC_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [COORD_BITS-1:0]         first_start_x,
	input  logic signed [COORD_BITS-1:0]         first_start_y,
	input  logic signed [COORD_BITS-1:0]         first_end_x,
	input  logic signed [COORD_BITS-1:0]         first_end_y,
	input  logic signed [COORD_BITS-1:0]         second_start_x,
	input  logic signed [COORD_BITS-1:0]         second_start_y,
	input  logic signed [COORD_BITS-1:0]         second_end_x,
	input  logic signed [COORD_BITS-1:0]         second_end_y,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [SCORE_FRAC_BITS:0]             angle_score,
	output logic [SCORE_FRAC_BITS:0]             scale_score,
	output logic [SCORE_FRAC_BITS:0]             position_score,
	output logic [SCORE_FRAC_BITS:0]             visibility_score,
	input  logic                                 cfg_wr_en,
	input  logic [epcs_pkg::MML_BITS-1:0]        cfg_wr_data
);

	localparam int C     = COORD_BITS;
	localparam int F     = SCORE_FRAC_BITS;
	localparam int G     = epcs_pkg::LEN_GUARD_BITS;
	localparam int MML_W = epcs_pkg::MML_BITS;
	localparam int D     = C + 1;            // edge deltas
	localparam int MW    = C + 2;            // twice the midpoint offset
	localparam int NW    = 2 * D;            // squared lengths, dot products
	localparam int TW    = NW + 2;           // projection offsets
	localparam int SIW   = NW + 2 + 2 * G;   // root input for lengths
	localparam int RW    = SIW / 2;
	localparam int SW    = RW + 1;           // sum of lengths
	localparam int QW    = F + 1;            // score width
	localparam int AQW   = 2 * F + 1;
	localparam int CW    = (SW > MML_W + 1 + G) ? SW : MML_W + 1 + G;

	localparam int A_END = 5 + AQW + QW;
	localparam int S_END = 3 + RW + 3 + QW;
	localparam int V_END = 5 + QW;
	localparam int END_AS = (A_END > S_END) ? A_END : S_END;
	localparam int END_ST = (END_AS > V_END) ? END_AS : V_END;
	localparam int TOT   = END_ST + 1;
	localparam int A_DLY = TOT - A_END;
	localparam int S_DLY = TOT - S_END;
	localparam int V_DLY = TOT - V_END;

	localparam logic [F:0] ONE_SCORE = {1'b1, {F{1'b0}}};

	logic adv;
	logic [MML_W-1:0] mml_q;
	logic vld_q [1:TOT];

	assign adv      = !vld_q[TOT] || out_ready;
	assign in_ready = adv;
	assign out_valid = vld_q[TOT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mml_q <= epcs_pkg::MML_RESET;
		end else if (cfg_wr_en) begin
			mml_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= TOT; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else if (adv) begin
			vld_q[1] <= in_valid;
			for (int i = 2; i <= TOT; i++) begin
				vld_q[i] <= vld_q[i-1];
			end
		end
	end

	// ---------------- front end: deltas, products, sums ----------------
	logic signed [D-1:0]    dx1_s1, dy1_s1, dx2_s1, dy2_s1;
	logic signed [MW-1:0]   mx_s1, my_s1;
	logic signed [D-1:0]    p0x_s1, p0y_s1, p1x_s1, p1y_s1;
	logic signed [D-1:0]    q0x_s1, q0y_s1, q1x_s1, q1y_s1;

	logic signed [NW-1:0]   xx1_s2, yy1_s2, xx2_s2, yy2_s2, dxx_s2, dyy_s2;
	logic signed [2*MW-1:0] mxx_s2, myy_s2;
	logic signed [NW-1:0]   t0x_s2, t0y_s2, t1x_s2, t1y_s2;
	logic signed [NW-1:0]   u0x_s2, u0y_s2, u1x_s2, u1y_s2;

	logic [NW-1:0]          n1_s3, n2_s3;
	logic signed [NW-1:0]   dot_s3;
	logic [NW:0]            m2_s3;
	logic signed [NW-1:0]   t0_s3, t1_s3, u0_s3, u1_s3;

	logic [NW-1:0]          adot_s4, n1_s4, n2_s4;
	logic                   aok_s4;
	logic [TW-2:0]          offp_s4, offq_s4;

	logic [2*NW-1:0]        an_s5, ad_s5;
	logic [NW+F-1:0]        vpn_s5, vqn_s5;
	logic [NW-1:0]          vpd_s5, vqd_s5;

	logic signed [TW-1:0]   offp_c, offq_c;
	logic                   vp_ok, vq_ok;

	assign offp_c = $signed({2'b00, n2_s3}) - TW'(t0_s3) - TW'(t1_s3);
	assign offq_c = $signed({2'b00, n1_s3}) - TW'(u0_s3) - TW'(u1_s3);
	assign vp_ok  = {1'b0, adot_s4} > offp_s4;
	assign vq_ok  = {1'b0, adot_s4} > offq_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			dx1_s1 <= D'(first_end_x) - D'(first_start_x);
			dy1_s1 <= D'(first_end_y) - D'(first_start_y);
			dx2_s1 <= D'(second_end_x) - D'(second_start_x);
			dy2_s1 <= D'(second_end_y) - D'(second_start_y);
			mx_s1  <= MW'(first_start_x) + MW'(first_end_x)
				- MW'(second_start_x) - MW'(second_end_x);
			my_s1  <= MW'(first_start_y) + MW'(first_end_y)
				- MW'(second_start_y) - MW'(second_end_y);
			p0x_s1 <= D'(first_start_x) - D'(second_start_x);
			p0y_s1 <= D'(first_start_y) - D'(second_start_y);
			p1x_s1 <= D'(first_end_x) - D'(second_start_x);
			p1y_s1 <= D'(first_end_y) - D'(second_start_y);
			q0x_s1 <= D'(second_start_x) - D'(first_start_x);
			q0y_s1 <= D'(second_start_y) - D'(first_start_y);
			q1x_s1 <= D'(second_end_x) - D'(first_start_x);
			q1y_s1 <= D'(second_end_y) - D'(first_start_y);

			xx1_s2 <= NW'(dx1_s1) * NW'(dx1_s1);
			yy1_s2 <= NW'(dy1_s1) * NW'(dy1_s1);
			xx2_s2 <= NW'(dx2_s1) * NW'(dx2_s1);
			yy2_s2 <= NW'(dy2_s1) * NW'(dy2_s1);
			dxx_s2 <= NW'(dx1_s1) * NW'(dx2_s1);
			dyy_s2 <= NW'(dy1_s1) * NW'(dy2_s1);
			mxx_s2 <= (2*MW)'(mx_s1) * (2*MW)'(mx_s1);
			myy_s2 <= (2*MW)'(my_s1) * (2*MW)'(my_s1);
			t0x_s2 <= NW'(p0x_s1) * NW'(dx2_s1);
			t0y_s2 <= NW'(p0y_s1) * NW'(dy2_s1);
			t1x_s2 <= NW'(p1x_s1) * NW'(dx2_s1);
			t1y_s2 <= NW'(p1y_s1) * NW'(dy2_s1);
			u0x_s2 <= NW'(q0x_s1) * NW'(dx1_s1);
			u0y_s2 <= NW'(q0y_s1) * NW'(dy1_s1);
			u1x_s2 <= NW'(q1x_s1) * NW'(dx1_s1);
			u1y_s2 <= NW'(q1y_s1) * NW'(dy1_s1);

			n1_s3  <= $unsigned(xx1_s2 + yy1_s2);
			n2_s3  <= $unsigned(xx2_s2 + yy2_s2);
			dot_s3 <= dxx_s2 + dyy_s2;
			m2_s3  <= (NW+1)'($unsigned(mxx_s2 + myy_s2));
			t0_s3  <= t0x_s2 + t0y_s2;
			t1_s3  <= t1x_s2 + t1y_s2;
			u0_s3  <= u0x_s2 + u0y_s2;
			u1_s3  <= u1x_s2 + u1y_s2;

			adot_s4 <= dot_s3[NW-1] ? $unsigned(-dot_s3) : $unsigned(dot_s3);
			n1_s4   <= n1_s3;
			n2_s4   <= n2_s3;
			aok_s4  <= (|n1_s3) && (|n2_s3);
			offp_s4 <= offp_c[TW-1] ? (TW-1)'($unsigned(-offp_c))
				: (TW-1)'($unsigned(offp_c));
			offq_s4 <= offq_c[TW-1] ? (TW-1)'($unsigned(-offq_c))
				: (TW-1)'($unsigned(offq_c));

			// no answer: divide zero by one so the unit returns zero
			if (aok_s4) begin
				an_s5 <= (2*NW)'(adot_s4) * (2*NW)'(adot_s4);
				ad_s5 <= (2*NW)'(n1_s4) * (2*NW)'(n2_s4);
			end else begin
				an_s5 <= '0;
				ad_s5 <= (2*NW)'(1);
			end
			// the projected span of either edge on the other is |dot|
			if (vp_ok) begin
				vpn_s5 <= {NW'(adot_s4 - NW'(offp_s4)), {F{1'b0}}};
				vpd_s5 <= adot_s4;
			end else begin
				vpn_s5 <= '0;
				vpd_s5 <= NW'(1);
			end
			if (vq_ok) begin
				vqn_s5 <= {NW'(adot_s4 - NW'(offq_s4)), {F{1'b0}}};
				vqd_s5 <= adot_s4;
			end else begin
				vqn_s5 <= '0;
				vqd_s5 <= NW'(1);
			end
		end
	end

	// ---------------- angle ----------------
	logic [AQW-1:0] cos2;
	logic [F:0]     ang_root;

	epcs_div #(.NUM_W(2*NW + 2*F), .DEN_W(2*NW), .QUO_W(AQW)) u_ang_div (
		.clk (clk),
		.en  (adv),
		.num ({an_s5, {(2*F){1'b0}}}),
		.den (ad_s5),
		.quo (cos2)
	);

	epcs_isqrt #(.IN_W(2*F + 2)) u_ang_sqrt (
		.clk  (clk),
		.en   (adv),
		.val  ({1'b0, cos2}),
		.root (ang_root)
	);

	// ---------------- visibility ----------------
	logic [F:0] vis_p, vis_q;

	epcs_div #(.NUM_W(NW + F), .DEN_W(NW), .QUO_W(QW)) u_visp_div (
		.clk (clk),
		.en  (adv),
		.num (vpn_s5),
		.den (vpd_s5),
		.quo (vis_p)
	);

	epcs_div #(.NUM_W(NW + F), .DEN_W(NW), .QUO_W(QW)) u_visq_div (
		.clk (clk),
		.en  (adv),
		.num (vqn_s5),
		.den (vqd_s5),
		.quo (vis_q)
	);

	// ---------------- lengths, scale, position ----------------
	logic [RW-1:0] len1, len2, mdist;

	epcs_isqrt #(.IN_W(SIW)) u_len1_sqrt (
		.clk  (clk),
		.en   (adv),
		.val  ({2'b00, n1_s3, {(2*G){1'b0}}}),
		.root (len1)
	);

	epcs_isqrt #(.IN_W(SIW)) u_len2_sqrt (
		.clk  (clk),
		.en   (adv),
		.val  ({2'b00, n2_s3, {(2*G){1'b0}}}),
		.root (len2)
	);

	epcs_isqrt #(.IN_W(SIW)) u_mid_sqrt (
		.clk  (clk),
		.en   (adv),
		.val  ({1'b0, m2_s3, {(2*G){1'b0}}}),
		.root (mdist)
	);

	logic [SW-1:0]     lsum_q, lsum2_q;
	logic [RW-1:0]     lmin_q, lmax_q, md_q, md2_q;
	logic              mok_q, mok2_q;
	logic [2*RW:0]     as_q;
	logic [2*RW+1:0]   ss_q;
	logic [2*RW-1:0]   ab_q;
	logic [2*RW+2+F:0] scn_q;
	logic [2*RW+2:0]   scd_q;
	logic [SW+F-1:0]   pn_q;
	logic [RW+1:0]     pd_q;
	logic [SW-1:0]     lsum_c;

	assign lsum_c = SW'(len1) + SW'(len2);

	always_ff @(posedge clk) begin
		if (adv) begin
			lsum_q <= lsum_c;
			lmin_q <= (len1 < len2) ? len1 : len2;
			lmax_q <= (len1 < len2) ? len2 : len1;
			md_q   <= mdist;
			// twice the mean length against twice the register, both with G fraction bits
			mok_q  <= CW'(lsum_c) > (CW'(mml_q) << (G + 1));

			as_q    <= (2*RW+1)'(lmin_q) * (2*RW+1)'(lsum_q);
			ss_q    <= (2*RW+2)'(lsum_q) * (2*RW+2)'(lsum_q);
			ab_q    <= (2*RW)'(lmin_q) * (2*RW)'(lmax_q);
			lsum2_q <= lsum_q;
			md2_q   <= md_q;
			mok2_q  <= mok_q;

			if (mok2_q) begin
				scn_q <= {as_q, 2'b00, {F{1'b0}}};
				scd_q <= (2*RW+3)'(ss_q) + (2*RW+3)'({ab_q, 2'b00});
				pn_q  <= {lsum2_q, {F{1'b0}}};
				pd_q  <= (RW+2)'(lsum2_q) + (RW+2)'(md2_q);
			end else begin
				scn_q <= '0;
				scd_q <= (2*RW+3)'(1);
				pn_q  <= '0;
				pd_q  <= (RW+2)'(1);
			end
		end
	end

	logic [F:0] scale_c, pos_c;

	epcs_div #(.NUM_W(2*RW + 3 + F), .DEN_W(2*RW + 3), .QUO_W(QW)) u_scale_div (
		.clk (clk),
		.en  (adv),
		.num (scn_q),
		.den (scd_q),
		.quo (scale_c)
	);

	epcs_div #(.NUM_W(SW + F), .DEN_W(RW + 2), .QUO_W(QW)) u_pos_div (
		.clk (clk),
		.en  (adv),
		.num (pn_q),
		.den (pd_q),
		.quo (pos_c)
	);

	// ---------------- align branches to the output register ----------------
	logic [F:0]     ang_dly_q [0:A_DLY];
	logic [2*F+1:0] sp_dly_q  [0:S_DLY];
	logic [F:0]     vis_dly_q [0:V_DLY];

	assign ang_dly_q[0] = ang_root;
	assign sp_dly_q[0]  = {scale_c, pos_c};
	assign vis_dly_q[0] = (vis_p < vis_q) ? vis_p : vis_q;

	for (genvar i = 1; i <= A_DLY; i++) begin : g_ang_dly
		always_ff @(posedge clk) begin
			if (adv) begin
				ang_dly_q[i] <= ang_dly_q[i-1];
			end
		end
	end

	for (genvar i = 1; i <= S_DLY; i++) begin : g_sp_dly
		always_ff @(posedge clk) begin
			if (adv) begin
				sp_dly_q[i] <= sp_dly_q[i-1];
			end
		end
	end

	for (genvar i = 1; i <= V_DLY; i++) begin : g_vis_dly
		always_ff @(posedge clk) begin
			if (adv) begin
				vis_dly_q[i] <= vis_dly_q[i-1];
			end
		end
	end

	assign angle_score      = ang_dly_q[A_DLY];
	assign scale_score      = sp_dly_q[S_DLY][2*F+1:F+1];
	assign position_score   = sp_dly_q[S_DLY][F:0];
	assign visibility_score = vis_dly_q[V_DLY];

	// ---------------- checks ----------------
	a_stall_only_on_held_result: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("pipe stalled without a waiting result");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> angle_score <= ONE_SCORE)
		else $error("angle score above one");

	a_scale_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> scale_score <= ONE_SCORE && position_score <= ONE_SCORE)
		else $error("scale or position score above one");

	a_vis_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> visibility_score <= ONE_SCORE)
		else $error("visibility score above one");

endmodule
